FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; take in by include before use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LSD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lsd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lsd assertion failed");

`endif

FILE: hdl/lsd_pkg.sv
// shared types and constants of the lsb stego stream decoder
// no dependencies
package lsd_pkg;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int VALUE_W   = 32;
  localparam int KIND_W    = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // hidden data layout
  localparam int MAGIC_CHARS = 2;
  localparam int MAGIC_BITS  = MAGIC_CHARS * BYTE_W;
  localparam int LEN_BITS    = 32;
  localparam int BIT_IDX_W   = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD   = 1'd1;

  localparam logic [CFG_W-1:0] HEADER_BYTES_RST = 16'd54;
  localparam logic [CFG_W-1:0] MAGIC_WORD_RST   = 16'h2A23;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_EXT_CHAR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECRET     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SECRET_LEN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MISMATCH   = 2'd3;

  // result queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } res_t;

endpackage

FILE: hdl/lsd_front.sv
// front end: takes carrier beats, skips the header, assembles hidden bits
// and classifies each finished item; depends on lsd_pkg
module lsd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsd_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           beat_accept,
  input  logic [lsd_pkg::BYTE_W-1:0]     carrier_byte,
  input  logic                           start_of_image,
  output logic                           push_valid,
  output lsd_pkg::res_t                  push_data
);
  import lsd_pkg::*;

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_MAGIC    = 3'd1;
  localparam logic [2:0] PH_EXT_LEN  = 3'd2;
  localparam logic [2:0] PH_EXT_CHR  = 3'd3;
  localparam logic [2:0] PH_SEC_LEN  = 3'd4;
  localparam logic [2:0] PH_SEC_BYTE = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;

  logic [CFG_W-1:0]     header_bytes_r;
  logic [CFG_W-1:0]     magic_word_r;
  logic [2:0]           phase_r, phase_nxt;
  logic [CFG_W-1:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic [VALUE_W-1:0]   asm_r, asm_nxt;
  logic [BIT_IDX_W-1:0] idx_r, idx_nxt;
  logic [VALUE_W-1:0]   ext_rem_r, ext_rem_nxt;
  logic [VALUE_W-1:0]   sec_rem_r, sec_rem_nxt;
  logic                 res_valid;
  res_t                 res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_bytes_r <= HEADER_BYTES_RST;
      magic_word_r   <= MAGIC_WORD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_BYTES: header_bytes_r <= cfg_wdata;
        REG_MAGIC_WORD:   magic_word_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-beat decode step
  always_comb begin
    logic [VALUE_W-1:0]   item;
    logic [BIT_IDX_W-1:0] last_idx;
    logic [VALUE_W-1:0]   dec;
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    asm_nxt     = asm_r;
    idx_nxt     = idx_r;
    ext_rem_nxt = ext_rem_r;
    sec_rem_nxt = sec_rem_r;
    res_valid   = 1'b0;
    res         = '0;
    item        = '0;
    last_idx    = '0;
    dec         = '0;
    if (beat_accept) begin
      // new image restarts all decode state
      if (start_of_image) begin
        phase_nxt   = PH_HEADER;
        hdr_cnt_nxt = '0;
        asm_nxt     = '0;
        idx_nxt     = '0;
        ext_rem_nxt = '0;
        sec_rem_nxt = '0;
      end
      // header skip
      if (phase_nxt == PH_HEADER) begin
        if (hdr_cnt_nxt < header_bytes_r) begin
          hdr_cnt_nxt = hdr_cnt_nxt + 1'b1;
        end else begin
          phase_nxt = PH_MAGIC;
          asm_nxt   = '0;
          idx_nxt   = '0;
        end
      end
      // bit gathering for data phases
      if (phase_nxt != PH_HEADER && phase_nxt <= PH_SEC_BYTE) begin
        if (phase_nxt == PH_MAGIC) begin
          last_idx = BIT_IDX_W'(MAGIC_BITS - 1);
        end else if (phase_nxt == PH_EXT_LEN || phase_nxt == PH_SEC_LEN) begin
          last_idx = BIT_IDX_W'(LEN_BITS - 1);
        end else begin
          last_idx = BIT_IDX_W'(BYTE_W - 1);
        end
        dec  = VALUE_W'(carrier_byte[0]) << idx_nxt;
        item = asm_nxt | dec;
        if (idx_nxt != last_idx) begin
          asm_nxt = item;
          idx_nxt = idx_nxt + 1'b1;
        end else begin
          asm_nxt = '0;
          idx_nxt = '0;
          unique case (phase_nxt)
            PH_MAGIC: begin
              if (item[MAGIC_BITS-1:0] != magic_word_r[MAGIC_BITS-1:0]) begin
                phase_nxt = PH_DONE;
                res_valid = 1'b1;
                res.kind  = KIND_MISMATCH;
                res.value = VALUE_W'(item[MAGIC_BITS-1:0]);
              end else begin
                phase_nxt = PH_EXT_LEN;
              end
            end
            PH_EXT_LEN: begin
              ext_rem_nxt = item;
              phase_nxt   = (item == '0) ? PH_SEC_LEN : PH_EXT_CHR;
            end
            PH_EXT_CHR: begin
              ext_rem_nxt = ext_rem_nxt - 1'b1;
              if (ext_rem_nxt == '0) phase_nxt = PH_SEC_LEN;
              res_valid = 1'b1;
              res.kind  = KIND_EXT_CHAR;
              res.value = VALUE_W'(item[BYTE_W-1:0]);
            end
            PH_SEC_LEN: begin
              sec_rem_nxt = item;
              phase_nxt   = (item == '0) ? PH_DONE : PH_SEC_BYTE;
              res_valid   = 1'b1;
              res.kind    = KIND_SECRET_LEN;
              res.value   = item;
              res.last    = (item == '0);
            end
            default: begin
              sec_rem_nxt = sec_rem_nxt - 1'b1;
              if (sec_rem_nxt == '0) phase_nxt = PH_DONE;
              res_valid = 1'b1;
              res.kind  = KIND_SECRET;
              res.value = VALUE_W'(item[BYTE_W-1:0]);
              res.last  = (sec_rem_nxt == '0);
            end
          endcase
        end
      end
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      asm_r     <= '0;
      idx_r     <= '0;
      ext_rem_r <= '0;
      sec_rem_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      asm_r     <= asm_nxt;
      idx_r     <= idx_nxt;
      ext_rem_r <= ext_rem_nxt;
      sec_rem_r <= sec_rem_nxt;
    end
  end

  assign push_valid = res_valid;
  assign push_data  = res;

endmodule

FILE: hdl/lsd_queue.sv
// short result queue between the front end and the output stage
// depends on lsd_pkg
module lsd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lsd_pkg::res_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output lsd_pkg::res_t head
);
  import lsd_pkg::*;

  res_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: hdl/lsd_back.sv
// back end: output register that drains the result queue toward the receiver
// depends on lsd_pkg
module lsd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  lsd_pkg::res_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output lsd_pkg::res_t out_data
);
  import lsd_pkg::*;

  logic valid_r;
  res_t data_r;

  // load when the register is free or its beat leaves this cycle
  assign q_pop = q_not_empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= q_head;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: hdl/lsb_stego_stream_decoder.sv
// Top level of the lsb stego stream decoder.
// Depends on lsd_pkg, lsd_front, lsd_queue and lsd_back.
//
// Usage:
//   in_*  : one carrier image byte per beat, in file order; raise
//           in_start_of_image on the first byte of each image.
//   out_* : decoded results; out_kind tells extension character, secret
//           byte, secret length or magic mismatch, out_value carries it and
//           out_last_of_payload marks the end of the secret.
//   cfg_* : write header_bytes (index 0) or magic_word (index 1) while idle.
// A result enters the queue as its last byte is taken, then the output
// register. Throughput: one byte per cycle while in_ready is high, set by
// the single front-end decode step and the one-per-cycle queue drain.
// Reset: decoding starts as if an image had just begun, header_bytes = 54,
// magic_word = "#*", queue and output register empty.
// Stall: a low out_ready keeps the result in the output register; the
// two-entry queue absorbs the next results, and in_ready drops only when
// the queue is full.
module lsb_stego_stream_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsd_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lsd_pkg::BYTE_W-1:0]     in_carrier_byte,
  input  logic                           in_start_of_image,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lsd_pkg::KIND_W-1:0]     out_kind,
  output logic [lsd_pkg::VALUE_W-1:0]    out_value,
  output logic                           out_last_of_payload
);
  import lsd_pkg::*;

  logic beat_accept;
  logic push_valid;
  res_t push_data;
  logic q_full, q_not_empty, q_pop;
  res_t q_head;
  res_t out_data;

  assign in_ready    = !q_full;
  assign beat_accept = in_valid && in_ready;

  // classify incoming beats
  lsd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .beat_accept    (beat_accept),
    .carrier_byte   (in_carrier_byte),
    .start_of_image (in_start_of_image),
    .push_valid     (push_valid),
    .push_data      (push_data)
  );

  // decouple front and back
  lsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // output register
  lsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  assign out_kind            = out_data.kind;
  assign out_value           = out_data.value;
  assign out_last_of_payload = out_data.last;

endmodule

FILE: hdl/lsd_checker.sv
// port-level checks of the lsb stego stream decoder, bound to the top level
// depends on lsd_pkg and assert_macros.svh
`include "assert_macros.svh"

module lsd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lsd_pkg::KIND_W-1:0]     out_kind,
  input logic [lsd_pkg::VALUE_W-1:0]    out_value,
  input logic                           out_last_of_payload
);
  import lsd_pkg::*;

  // a stalled result holds
  `LSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_value) && $stable(out_last_of_payload))

  // only secret bytes and lengths may end the payload
  `LSD_ASSERT_IMPLY(a_last_kind, clk, rst_n, out_valid && (out_kind == KIND_EXT_CHAR || out_kind == KIND_MISMATCH), !out_last_of_payload)

  // a secret length ends the payload exactly when it is zero
  `LSD_ASSERT_IMPLY(a_len_last, clk, rst_n, out_valid && out_kind == KIND_SECRET_LEN, out_last_of_payload == (out_value == '0))

  // characters and bytes fit in one byte
  `LSD_ASSERT_IMPLY(a_char_width, clk, rst_n, out_valid && (out_kind == KIND_EXT_CHAR || out_kind == KIND_SECRET), out_value[VALUE_W-1:BYTE_W] == '0)

  // input stalls only behind a held result beat
  `LSD_ASSERT_IMPLY(a_stall_has_out, clk, rst_n, !in_ready, out_valid)

endmodule

bind lsb_stego_stream_decoder lsd_checker u_lsd_checker (.*);
